### rtl/mqf_pkg.sv
// ----------------------------------------------------------------------------
// mqf_pkg
// Shared widths, codes and defaults for the multi-queue FIFO with dedup.
// ----------------------------------------------------------------------------
`default_nettype none

package mqf_pkg;

  // Field widths of the request and response beats
  localparam int unsigned OpW     = 2;
  localparam int unsigned QidW    = 8;
  localparam int unsigned MidW    = 16;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CountW  = 7;

  // Default geometry
  localparam int unsigned NumQueuesDef  = 16;
  localparam int unsigned QueueDepthDef = 64;

  // Operation codes
  localparam logic [OpW-1:0] OP_JOIN  = 2'd0;
  localparam logic [OpW-1:0] OP_POP   = 2'd1;
  localparam logic [OpW-1:0] OP_COUNT = 2'd2;
  localparam logic [OpW-1:0] OP_BAD   = 2'd3;

  // Status codes
  localparam logic [StatusW-1:0] ST_OK      = 3'd0;
  localparam logic [StatusW-1:0] ST_INVALID = 3'd1;
  localparam logic [StatusW-1:0] ST_ALREADY = 3'd2;
  localparam logic [StatusW-1:0] ST_FULL    = 3'd3;
  localparam logic [StatusW-1:0] ST_EMPTY   = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DESC,
    S_SCAN,
    S_APPEND,
    S_POP,
    S_DONE
  } mqf_state_e;

endpackage

`default_nettype wire

### rtl/mqf_req_if.sv
// ----------------------------------------------------------------------------
// mqf_req_if
// Request channel: operation, queue number and member id.
// ----------------------------------------------------------------------------
`default_nettype none

interface mqf_req_if
  import mqf_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [OpW-1:0]    operation;
  logic [QidW-1:0]   queue_id;
  logic [MidW-1:0]   member_id;

  modport source (output valid, output operation, output queue_id, output member_id,
                  input ready);
  modport sink   (input valid, input operation, input queue_id, input member_id,
                  output ready);
endinterface

`default_nettype wire

### rtl/mqf_rsp_if.sv
// ----------------------------------------------------------------------------
// mqf_rsp_if
// Response channel: status, popped member and occupancy.
// ----------------------------------------------------------------------------
`default_nettype none

interface mqf_rsp_if
  import mqf_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [MidW-1:0]    member_out;
  logic [CountW-1:0]  count_out;

  modport source (output valid, output status, output member_out, output count_out,
                  input ready);
  modport sink   (input valid, input status, input member_out, input count_out,
                  output ready);
endinterface

`default_nettype wire

### rtl/mqf_ram.sv
// ----------------------------------------------------------------------------
// mqf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mqf_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/multi_queue_fifo_dedup.sv
// ----------------------------------------------------------------------------
// multi_queue_fifo_dedup
// Bank of ring FIFOs of member ids with duplicate rejection on join.
// ----------------------------------------------------------------------------
// One request is handled at a time. A count query finishes once the
// descriptor is read, a pop once the head slot is read, and an invalid request
// goes straight to the result. A join stops early when a duplicate turns up;
// otherwise it walks the live entries of its queue through the single read
// port of the slot memory, one entry per cycle. The next request is
// accepted in the cycle after the result is loaded. Head, tail and occupancy of
// each queue sit in a small descriptor memory; a valid bit per queue makes an
// unwritten descriptor read as zero, so no clearing pass runs after reset. A
// finished result waits in an output register while the next request is
// already accepted.
`default_nettype none

module multi_queue_fifo_dedup
  import mqf_pkg::*;
#(
  parameter int unsigned NUM_QUEUES  = NumQueuesDef,
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mqf_req_if.sink    req_i,
  mqf_rsp_if.source  rsp_o
);

  localparam int unsigned QW   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned PW   = $clog2(QUEUE_DEPTH);
  localparam int unsigned OW   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SD   = NUM_QUEUES * QUEUE_DEPTH;
  localparam int unsigned SAW  = $clog2(SD);
  localparam int unsigned DW   = 2 * PW + OW;
  localparam logic [QidW-1:0] NQ = QidW'(NUM_QUEUES);
  localparam logic [PW-1:0]   LastPos = PW'(QUEUE_DEPTH - 1);
  localparam logic [OW-1:0]   FullOcc = OW'(QUEUE_DEPTH);

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] pos);
    return (pos == LastPos) ? '0 : pos + PW'(1);
  endfunction

  mqf_state_e state_q, state_d;

  logic [OpW-1:0]     op_q, op_d;
  logic [MidW-1:0]    mid_q, mid_d;
  logic [QW-1:0]      qidx_q, qidx_d;
  logic [SAW-1:0]     base_q, base_d;
  logic [PW-1:0]      head_q, head_d, tail_q, tail_d, scan_pos_q, scan_pos_d;
  logic [OW-1:0]      occ_q, occ_d, cmp_cnt_q, cmp_cnt_d;
  logic [StatusW-1:0] res_status_q, res_status_d;
  logic [MidW-1:0]    res_member_q, res_member_d;
  logic [CountW-1:0]  res_count_q, res_count_d;
  logic               desc_vld_q, desc_vld_d;
  logic [NUM_QUEUES-1:0] qvld_q;

  logic               out_vld_q;
  logic [StatusW-1:0] out_status_q;
  logic [MidW-1:0]    out_member_q;
  logic [CountW-1:0]  out_count_q;
  logic               out_load;

  // Memory ports
  logic              slot_we;
  logic [SAW-1:0]    slot_waddr, slot_raddr;
  logic [MidW-1:0]   slot_wdata, slot_rdata;
  logic              desc_we;
  logic [QW-1:0]     desc_raddr;
  logic [DW-1:0]     desc_wdata, desc_rdata;

  logic [QW-1:0]     q_in;
  logic              bad_in;
  logic [PW-1:0]     rd_head, rd_tail;
  logic [OW-1:0]     rd_occ;

  assign q_in   = QW'(req_i.queue_id - QidW'(1));
  assign bad_in = (req_i.queue_id == '0) || (req_i.queue_id > NQ) ||
                  (req_i.operation == OP_BAD) ||
                  ((req_i.operation == OP_JOIN) && (req_i.member_id == '0));

  // An unwritten descriptor reads as an empty queue
  assign rd_head = desc_vld_q ? desc_rdata[DW-1 -: PW]     : '0;
  assign rd_tail = desc_vld_q ? desc_rdata[OW+PW-1 -: PW]  : '0;
  assign rd_occ  = desc_vld_q ? desc_rdata[OW-1:0]         : '0;

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    mid_d        = mid_q;
    qidx_d       = qidx_q;
    base_d       = base_q;
    head_d       = head_q;
    tail_d       = tail_q;
    occ_d        = occ_q;
    scan_pos_d   = scan_pos_q;
    cmp_cnt_d    = cmp_cnt_q;
    res_status_d = res_status_q;
    res_member_d = res_member_q;
    res_count_d  = res_count_q;
    desc_vld_d   = desc_vld_q;
    req_i.ready  = 1'b0;
    out_load     = 1'b0;
    slot_we      = 1'b0;
    slot_waddr   = base_q + SAW'(tail_q);
    slot_wdata   = mid_q;
    slot_raddr   = base_q + SAW'(scan_pos_q);
    desc_we      = 1'b0;
    desc_raddr   = q_in;
    desc_wdata   = {head_q, ring_next(tail_q), occ_q + OW'(1)};

    unique case (state_q)
      S_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          op_d         = req_i.operation;
          mid_d        = req_i.member_id;
          qidx_d       = q_in;
          base_d       = SAW'(q_in) * SAW'(QUEUE_DEPTH);
          desc_vld_d   = qvld_q[q_in];
          res_status_d = ST_OK;
          res_member_d = '0;
          res_count_d  = '0;
          if (bad_in) begin
            res_status_d = ST_INVALID;
            state_d      = S_DONE;
          end else begin
            state_d = S_DESC;
          end
        end
      end

      S_DESC: begin
        head_d = rd_head;
        tail_d = rd_tail;
        occ_d  = rd_occ;
        case (op_q)
          OP_COUNT: begin
            res_count_d = CountW'(rd_occ);
            state_d     = S_DONE;
          end
          OP_POP: begin
            if (rd_occ == '0) begin
              res_status_d = ST_EMPTY;
              state_d      = S_DONE;
            end else begin
              slot_raddr = base_q + SAW'(rd_head);
              state_d    = S_POP;
            end
          end
          default: begin
            if (rd_occ == '0) begin
              state_d = S_APPEND;
            end else begin
              // Prime the scan with the oldest entry
              slot_raddr = base_q + SAW'(rd_head);
              scan_pos_d = ring_next(rd_head);
              cmp_cnt_d  = '0;
              state_d    = S_SCAN;
            end
          end
        endcase
      end

      S_SCAN: begin
        if (slot_rdata == mid_q) begin
          res_status_d = ST_ALREADY;
          state_d      = S_DONE;
        end else if ((cmp_cnt_q + OW'(1)) == occ_q) begin
          state_d = S_APPEND;
        end else begin
          // Advance: fetch the next live entry while comparing this one
          scan_pos_d = ring_next(scan_pos_q);
          cmp_cnt_d  = cmp_cnt_q + OW'(1);
        end
      end

      S_APPEND: begin
        if (occ_q == FullOcc) begin
          res_status_d = ST_FULL;
        end else begin
          slot_we = 1'b1;
          desc_we = 1'b1;
        end
        state_d = S_DONE;
      end

      S_POP: begin
        res_member_d = slot_rdata;
        desc_we      = 1'b1;
        desc_wdata   = {ring_next(head_q), tail_q, occ_q - OW'(1)};
        state_d      = S_DONE;
      end

      S_DONE: begin
        // Hold until the output register is free
        if (!out_vld_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      qvld_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (desc_we) begin
        qvld_q[qidx_q] <= 1'b1;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    mid_q        <= mid_d;
    qidx_q       <= qidx_d;
    base_q       <= base_d;
    head_q       <= head_d;
    tail_q       <= tail_d;
    occ_q        <= occ_d;
    scan_pos_q   <= scan_pos_d;
    cmp_cnt_q    <= cmp_cnt_d;
    res_status_q <= res_status_d;
    res_member_q <= res_member_d;
    res_count_q  <= res_count_d;
    desc_vld_q   <= desc_vld_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_member_q <= res_member_q;
      out_count_q  <= res_count_q;
    end
  end

  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.member_out = out_member_q;
  assign rsp_o.count_out  = out_count_q;

  // Descriptor writes land before the next descriptor read, since only one
  // request is in flight; no forwarding is needed.
  mqf_ram #(
    .Width (MidW),
    .Depth (SD)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  mqf_ram #(
    .Width (DW),
    .Depth (NUM_QUEUES)
  ) u_desc_ram (
    .clk_i   (clk_i),
    .we_i    (desc_we),
    .waddr_i (qidx_q),
    .wdata_i (desc_wdata),
    .raddr_i (desc_raddr),
    .rdata_o (desc_rdata)
  );

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (cmp_cnt_q < occ_q))
    else $error("scan ran past the live entries");

  a_append_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_we |-> ((op_q == OP_JOIN) && (occ_q < FullOcc)))
    else $error("slot written without room or outside a join");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP) |-> ((occ_q != '0) && (op_q == OP_POP)))
    else $error("pop of an empty queue");

  a_desc_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DESC) |-> (rd_occ <= FullOcc))
    else $error("descriptor occupancy above queue depth");

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_vld_q && (state_q == S_IDLE)))
    else $error("result load did not release the request side");

endmodule

`default_nettype wire
